// ----- rtl/lkc_pkg.sv -----
// Shared types and constants of the keyed entry cache.
package lkc_pkg;

  localparam int MaxEntries  = 64;
  localparam int SlotW       = $clog2(MaxEntries);
  localparam int CntW        = SlotW + 1;
  localparam int MaxKeyWords = 4;
  localparam int WordW       = 64;
  localparam int RowW        = MaxKeyWords * WordW;
  localparam int RankW       = SlotW;
  localparam int CapW        = 7;
  localparam int KwW         = 3;
  localparam int CfgW        = 7;
  localparam int CfgIdxW     = 2;
  localparam int FillW       = CntW;

  localparam logic [CapW-1:0] PromoteLimit = CapW'(64);
  localparam logic [CapW-1:0] CapReset     = CapW'(64);
  localparam logic [KwW-1:0]  KwReset      = KwW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgCapacity = 2'd0,
    CfgKeyWords = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } state_e;

  typedef struct packed {
    logic [WordW-1:0] addr_word0;
    logic [WordW-1:0] addr_word1;
    logic [WordW-1:0] addr_word2;
    logic [WordW-1:0] addr_word3;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] slot;
    logic       replaced;
  } out_t;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [SlotW-1:0] rd_idx;
    logic             update;
  } ctl_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] hit_slot;
    logic [RankW-1:0] hit_rank;
    logic             any;
    logic [RankW-1:0] best;
    logic [SlotW-1:0] lru_slot;
    logic [SlotW-1:0] free_slot;
  } scan_res_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic             age_all;
    logic [RankW-1:0] limit;
    logic             fill_inc;
  } upd_t;

endpackage

// ----- rtl/lkc_key_ram.sv -----
// Key memory: one row per entry holding all key words, registered read.
module lkc_key_ram (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [lkc_pkg::SlotW-1:0]          waddr_i,
  input  logic [lkc_pkg::RowW-1:0]           wdata_i,
  input  logic                               re_i,
  input  logic [lkc_pkg::SlotW-1:0]          raddr_i,
  output logic [lkc_pkg::RowW-1:0]           rdata_o
);

  logic [lkc_pkg::RowW-1:0] mem_q [lkc_pkg::MaxEntries];
  logic [lkc_pkg::RowW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lkc_seq.sv -----
// Sequencer that walks every slot once per lookup and then commits the update.
module lkc_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output lkc_pkg::ctl_t ctl_o
);

  lkc_pkg::state_e state_q, state_d;
  logic [lkc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic scan_last;

  assign scan_last = cnt_q[lkc_pkg::CntW-1];

  always_comb begin
    state_d = state_q;
    case (state_q)
      lkc_pkg::StIdle: begin
        if (start) begin
          state_d = lkc_pkg::StScan;
        end
      end
      lkc_pkg::StScan: begin
        if (scan_last) begin
          state_d = lkc_pkg::StUpdate;
        end
      end
      lkc_pkg::StUpdate: begin
        state_d = lkc_pkg::StIdle;
      end
      default: begin
        state_d = lkc_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    ctl_o  = '0;
    busy   = 1'b1;
    case (state_q)
      lkc_pkg::StIdle: begin
        busy = 1'b0;
        if (start) begin
          ctl_o.clear = 1'b1;
          cnt_d       = '0;
        end
      end
      lkc_pkg::StScan: begin
        ctl_o.rd_en  = !scan_last;
        ctl_o.rd_idx = cnt_q[lkc_pkg::SlotW-1:0];
        cnt_d        = cnt_q + lkc_pkg::CntW'(1);
      end
      lkc_pkg::StUpdate: begin
        ctl_o.update = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkc_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/lkc_scan.sv -----
// Shared compare unit: matches one stored row per cycle and tracks hit, oldest and free slots.
module lkc_scan (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  lkc_pkg::ctl_t                                  ctl_i,
  input  logic [lkc_pkg::RowW-1:0]                       row_i,
  input  lkc_pkg::in_t                                   key_i,
  input  logic [lkc_pkg::KwW-1:0]                        words_i,
  input  logic [lkc_pkg::MaxEntries-1:0]                 valid_i,
  input  logic [lkc_pkg::MaxEntries-1:0][lkc_pkg::RankW-1:0] rank_i,
  output lkc_pkg::scan_res_t                             res_o
);

  logic                      cmp_vld_q;
  logic [lkc_pkg::SlotW-1:0] cmp_idx_q;
  lkc_pkg::scan_res_t        res_q, res_d;
  logic                      free_found_q, free_found_d;
  logic [lkc_pkg::RowW-1:0]  key_row;
  logic                      eq;
  logic                      cur_valid;
  logic [lkc_pkg::RankW-1:0] cur_rank;

  assign key_row = {key_i.addr_word3, key_i.addr_word2, key_i.addr_word1, key_i.addr_word0};
  assign cur_valid = valid_i[cmp_idx_q];
  assign cur_rank  = rank_i[cmp_idx_q];

  always_comb begin
    eq = 1'b1;
    for (int w = 0; w < lkc_pkg::MaxKeyWords; w++) begin
      if ((lkc_pkg::KwW'(w) < words_i) &&
          (row_i[w*lkc_pkg::WordW +: lkc_pkg::WordW] !=
           key_row[w*lkc_pkg::WordW +: lkc_pkg::WordW])) begin
        eq = 1'b0;
      end
    end
  end

  always_comb begin
    res_d        = res_q;
    free_found_d = free_found_q;
    if (ctl_i.clear) begin
      res_d        = '0;
      free_found_d = 1'b0;
    end else if (cmp_vld_q) begin
      if (cur_valid) begin
        if (!res_q.found && eq) begin
          res_d.found    = 1'b1;
          res_d.hit_slot = cmp_idx_q;
          res_d.hit_rank = cur_rank;
        end
        if (!res_q.any || (cur_rank > res_q.best)) begin
          res_d.any      = 1'b1;
          res_d.best     = cur_rank;
          res_d.lru_slot = cmp_idx_q;
        end
      end else if (!free_found_q) begin
        free_found_d    = 1'b1;
        res_d.free_slot = cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
      res_q        <= '0;
    end else begin
      cmp_vld_q    <= ctl_i.rd_en;
      free_found_q <= free_found_d;
      res_q        <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= ctl_i.rd_idx;
  end

  assign res_o = res_q;

endmodule

// ----- rtl/lkc_lanes.sv -----
// Per-entry valid bits and recency ranks, aged in parallel, plus the fill count.
module lkc_lanes (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  lkc_pkg::upd_t                                      upd_i,
  output logic [lkc_pkg::MaxEntries-1:0]                     valid_o,
  output logic [lkc_pkg::MaxEntries-1:0][lkc_pkg::RankW-1:0] rank_o,
  output logic [lkc_pkg::FillW-1:0]                          fill_o
);

  logic [lkc_pkg::MaxEntries-1:0]                     valid_q, valid_d;
  logic [lkc_pkg::MaxEntries-1:0][lkc_pkg::RankW-1:0] rank_q, rank_d;
  logic [lkc_pkg::FillW-1:0]                          fill_q, fill_d;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    fill_d  = fill_q;
    if (upd_i.en) begin
      for (int i = 0; i < lkc_pkg::MaxEntries; i++) begin
        if (valid_q[i] && (upd_i.age_all || (rank_q[i] < upd_i.limit))) begin
          rank_d[i] = rank_q[i] + lkc_pkg::RankW'(1);
        end
        if (upd_i.slot == lkc_pkg::SlotW'(i)) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end
      end
      if (upd_i.fill_inc) begin
        fill_d = fill_q + lkc_pkg::FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
      fill_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      fill_q  <= fill_d;
    end
  end

  assign valid_o = valid_q;
  assign rank_o  = rank_q;
  assign fill_o  = fill_q;

endmodule

// ----- rtl/lru_keyed_entry_cache.sv -----
// Top level of the fully associative keyed cache with least-recent replacement.
//
// A lookup beat is accepted at a rising edge where start is high and busy is low; key_i
// carries the four address words, of which the first key_words take part in the compare.
// The block then reads one stored entry per cycle from the key memory and checks it in a
// single shared compare unit, which also tracks the oldest valid entry and the lowest
// free one. After all 64 entries it updates valid bits, recency ranks and, on a miss, the
// stored key; on a hit, ranks and valid bits change only while capacity is at most 64.
// The result beat appears on result_o with done_o high for exactly one cycle right after
// busy falls, and a new lookup may start in the cycle the result is shown. The receiver
// cannot stall, so a result must be taken in its cycle. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write it only while busy is low,
// which the block does not enforce. Reset empties the cache, sets capacity to 64 and
// key words to one; no clearing pass is needed as a stored key counts only when valid.
module lru_keyed_entry_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lkc_pkg::in_t                  key_i,
  output logic                          done_o,
  output lkc_pkg::out_t                 result_o,
  input  logic                          cfg_we_i,
  input  logic [lkc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lkc_pkg::CfgW-1:0]      cfg_data_i
);

  logic [lkc_pkg::CapW-1:0] capacity_q;
  logic [lkc_pkg::KwW-1:0]  key_words_q;
  lkc_pkg::in_t             key_q;
  lkc_pkg::ctl_t            ctl;
  lkc_pkg::scan_res_t       res;
  lkc_pkg::upd_t            upd;
  lkc_pkg::out_t            result_q, result_d;
  logic                     done_q;
  logic [lkc_pkg::RowW-1:0] row;
  logic [lkc_pkg::KwW-1:0]  words_eff;
  logic [lkc_pkg::CapW-1:0] cap_eff;
  logic                     full;
  logic                     evict;
  logic [lkc_pkg::MaxEntries-1:0]                     valid;
  logic [lkc_pkg::MaxEntries-1:0][lkc_pkg::RankW-1:0] rank;
  logic [lkc_pkg::FillW-1:0]                          fill;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= lkc_pkg::CapReset;
      key_words_q <= lkc_pkg::KwReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lkc_pkg::CfgCapacity: capacity_q  <= cfg_data_i[lkc_pkg::CapW-1:0];
        lkc_pkg::CfgKeyWords: key_words_q <= cfg_data_i[lkc_pkg::KwW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    words_eff = key_words_q;
    if (key_words_q == '0) begin
      words_eff = lkc_pkg::KwW'(1);
    end else if (key_words_q > lkc_pkg::KwW'(lkc_pkg::MaxKeyWords)) begin
      words_eff = lkc_pkg::KwW'(lkc_pkg::MaxKeyWords);
    end
    cap_eff = capacity_q;
    if (capacity_q == '0) begin
      cap_eff = lkc_pkg::CapW'(1);
    end else if (capacity_q > lkc_pkg::CapW'(lkc_pkg::MaxEntries)) begin
      cap_eff = lkc_pkg::CapW'(lkc_pkg::MaxEntries);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.clear) begin
      key_q <= key_i;
    end
  end

  lkc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  lkc_key_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (upd.en && !res.found),
    .waddr_i (upd.slot),
    .wdata_i ({key_q.addr_word3, key_q.addr_word2, key_q.addr_word1, key_q.addr_word0}),
    .re_i    (ctl.rd_en),
    .raddr_i (ctl.rd_idx),
    .rdata_o (row)
  );

  lkc_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .row_i   (row),
    .key_i   (key_q),
    .words_i (words_eff),
    .valid_i (valid),
    .rank_i  (rank),
    .res_o   (res)
  );

  assign full  = (fill >= lkc_pkg::FillW'(cap_eff));
  assign evict = !res.found && full && res.any;

  always_comb begin
    upd          = '0;
    upd.en       = ctl.update;
    result_d     = '0;
    if (res.found) begin
      upd.en    = ctl.update && (capacity_q <= lkc_pkg::PromoteLimit);
      upd.slot  = res.hit_slot;
      upd.limit = res.hit_rank;
    end else if (full) begin
      upd.slot  = res.lru_slot;
      upd.limit = res.best;
    end else begin
      upd.slot     = res.free_slot;
      upd.age_all  = 1'b1;
      upd.fill_inc = 1'b1;
    end
    result_d.hit      = res.found;
    result_d.slot     = 6'(upd.slot);
    result_d.replaced = evict;
  end

  lkc_lanes u_lanes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .valid_o (valid),
    .rank_o  (rank),
    .fill_o  (fill)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.update) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- rtl/lkc_checker.sv -----
// Port-level checks of the keyed cache and their binding to the top level.
module lkc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input lkc_pkg::out_t result_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result beat shown while a lookup is still running.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted lookup did not raise busy.");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("Lookup ended without a result beat.");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("One lookup produced more than one result beat.");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.hit) |-> !result_o.replaced)
    else $error("A hit reported an eviction.");

endmodule

bind lru_keyed_entry_cache lkc_checker u_lkc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ----- bench/testbench.sv -----
// Self-checking testbench for the fully associative keyed cache with least-recent replacement.
module testbench;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          start      = 1'b0;
  logic                          busy;
  lkc_pkg::in_t                  key_i      = '0;
  logic                          done_o;
  lkc_pkg::out_t                 result_o;
  logic                          cfg_we_i   = 1'b0;
  logic [lkc_pkg::CfgIdxW-1:0]   cfg_idx_i  = '0;
  logic [lkc_pkg::CfgW-1:0]      cfg_data_i = '0;

  lru_keyed_entry_cache DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .key_i     (key_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  lkc_pkg::in_t  pending_keys[$];
  lkc_pkg::out_t predicted_outcomes[$];
  lkc_pkg::in_t  key_pool[$];

  logic [lkc_pkg::WordW-1:0] stored_key [lkc_pkg::MaxEntries][lkc_pkg::MaxKeyWords];
  bit                        entry_live [lkc_pkg::MaxEntries];
  int                        recency    [lkc_pkg::MaxEntries];
  int                        fill_cnt   = 0;
  logic [lkc_pkg::CapW-1:0]  capacity_reg  = lkc_pkg::CapReset;
  logic [lkc_pkg::KwW-1:0]   key_words_reg = lkc_pkg::KwReset;

  int fail_cnt   = 0;
  int lookup_cnt = 0;
  int hit_cnt    = 0;
  int evict_cnt  = 0;
  int phase_cnt  = 0;
  int random_cnt = 0;
  int burst_left = 0;
  int gap_left   = 0;

  function automatic void age_entries(int limit);
    for (int i = 0; i < lkc_pkg::MaxEntries; i++) begin
      if (entry_live[i] && recency[i] < limit) recency[i]++;
    end
  endfunction

  function automatic lkc_pkg::out_t cache_lookup(lkc_pkg::in_t k);
    logic [lkc_pkg::WordW-1:0] words [lkc_pkg::MaxKeyWords];
    int   nw, cap, slot, best;
    bit   found, evict, same;
    lkc_pkg::out_t res;
    words[0] = k.addr_word0;
    words[1] = k.addr_word1;
    words[2] = k.addr_word2;
    words[3] = k.addr_word3;
    nw = (key_words_reg == 0) ? 1 :
         (key_words_reg > lkc_pkg::MaxKeyWords) ? lkc_pkg::MaxKeyWords : int'(key_words_reg);
    cap = (capacity_reg == 0) ? 1 :
          (capacity_reg > lkc_pkg::MaxEntries) ? lkc_pkg::MaxEntries : int'(capacity_reg);
    found = 1'b0;
    evict = 1'b0;
    slot  = 0;
    best  = 0;
    for (int i = 0; i < lkc_pkg::MaxEntries && !found; i++) begin
      if (entry_live[i]) begin
        same = 1'b1;
        for (int w = 0; w < nw; w++) begin
          if (stored_key[i][w] != words[w]) same = 1'b0;
        end
        if (same) begin
          found = 1'b1;
          slot  = i;
        end
      end
    end
    if (found) begin
      hit_cnt++;
      if (capacity_reg <= lkc_pkg::PromoteLimit) begin
        age_entries(recency[slot]);
        recency[slot] = 0;
      end
    end else begin
      if (fill_cnt >= cap) begin
        for (int i = 0; i < lkc_pkg::MaxEntries; i++) begin
          if (entry_live[i] && (!evict || recency[i] > best)) begin
            evict = 1'b1;
            best  = recency[i];
            slot  = i;
          end
        end
        age_entries(best);
        if (evict) evict_cnt++;
      end else begin
        for (int i = lkc_pkg::MaxEntries - 1; i >= 0; i--) begin
          if (!entry_live[i]) slot = i;
        end
        age_entries(lkc_pkg::MaxEntries + 1);
        fill_cnt++;
      end
      entry_live[slot] = 1'b1;
      recency[slot]    = 0;
      for (int w = 0; w < lkc_pkg::MaxKeyWords; w++) stored_key[slot][w] = words[w];
    end
    res.hit      = found;
    res.slot     = 6'(slot);
    res.replaced = evict;
    return res;
  endfunction

  function automatic logic [lkc_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return lkc_pkg::WordW'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Most lookups reuse a recent key, some with one word changed, so that hits,
  // near misses and ignored trailing words all show up regularly.
  function automatic lkc_pkg::in_t next_key();
    lkc_pkg::in_t k;
    int  span;
    if (key_pool.size() == 0 || $urandom_range(0, 9) < 4) begin
      k.addr_word0 = pick_word();
      k.addr_word1 = pick_word();
      k.addr_word2 = pick_word();
      k.addr_word3 = pick_word();
      key_pool.insert(key_pool.size(), k);
      if (key_pool.size() > 96) void'(key_pool.pop_front());
    end else begin
      span = $urandom_range(0, 1) ? 6 : key_pool.size();
      if (span > key_pool.size()) span = key_pool.size();
      k = key_pool[key_pool.size() - 1 - $urandom_range(0, span - 1)];
      case ($urandom_range(0, 7))
        0: k.addr_word0 = pick_word();
        1: k.addr_word1 = pick_word();
        2: k.addr_word2 = pick_word();
        3: k.addr_word3 = pick_word();
        default: ;
      endcase
    end
    return k;
  endfunction

  always @(posedge clk_i) begin : drive_proc
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_keys.size() > 0) begin
        key_i <= pending_keys.pop_front();
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    lkc_pkg::out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (predicted_outcomes.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("[%0t] result beat with no lookup outstanding: hit=%0b slot=%0d replaced=%0b",
                     $realtime, result_o.hit, result_o.slot, result_o.replaced);
          end
        end else begin
          want = predicted_outcomes.pop_front();
          if (want.hit !== result_o.hit || want.slot !== result_o.slot ||
              want.replaced !== result_o.replaced) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("[%0t] lookup result differs: want hit=%0b slot=%0d replaced=%0b",
                       $realtime, want.hit, want.slot, want.replaced);
              $display("[%0t]                         got hit=%0b slot=%0d replaced=%0b",
                       $realtime, result_o.hit, result_o.slot, result_o.replaced);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (lkc_pkg::cfg_idx_e'(cfg_idx_i))
          lkc_pkg::CfgCapacity: capacity_reg  = cfg_data_i[lkc_pkg::CapW-1:0];
          lkc_pkg::CfgKeyWords: key_words_reg = cfg_data_i[lkc_pkg::KwW-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        lookup_cnt++;
        predicted_outcomes.insert(predicted_outcomes.size(), cache_lookup(key_i));
      end
    end
  end

  task automatic write_reg(lkc_pkg::cfg_idx_e idx, logic [lkc_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Unused upper data bits of the key word count are filled at random.
  task automatic set_config(int cap, int kw);
    write_reg(lkc_pkg::CfgCapacity, lkc_pkg::CfgW'(cap));
    write_reg(lkc_pkg::CfgKeyWords, {4'($urandom_range(0, 15)), 3'(kw)});
    phase_cnt++;
  endtask

  task automatic push_key(logic [lkc_pkg::WordW-1:0] w0, logic [lkc_pkg::WordW-1:0] w1,
                          logic [lkc_pkg::WordW-1:0] w2, logic [lkc_pkg::WordW-1:0] w3);
    lkc_pkg::in_t k;
    k.addr_word0 = w0;
    k.addr_word1 = w1;
    k.addr_word2 = w2;
    k.addr_word3 = w3;
    pending_keys.insert(pending_keys.size(), k);
  endtask

  task automatic drain_lookups();
    do @(negedge clk_i);
    while (pending_keys.size() != 0 || start || predicted_outcomes.size() != 0);
  endtask

  initial begin : stimulus_proc
    int n;
    int cap_choices [14];
    cap_choices = '{1, 2, 3, 5, 8, 16, 31, 63, 64, 64, 65, 100, 127, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(4, 4);
    push_key('0, '0, '0, '0);
    push_key('1, '1, '1, '1);
    push_key('0, '0, '0, '0);
    push_key('0, '0, '0, 64'd1);
    push_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
             64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    push_key(64'd5, 64'd5, 64'd5, 64'd5);
    push_key('1, '1, '1, '1);
    drain_lookups();

    set_config(4, 1);
    push_key('0, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    push_key('1, '0, '0, '0);
    push_key(64'd7, '0, '0, '0);
    drain_lookups();

    set_config(0, 0);
    push_key(64'd9, '1, '0, '1);
    push_key(64'd9, '0, '1, '0);
    push_key(64'd10, '0, '0, '0);
    drain_lookups();

    set_config(127, 7);
    push_key(64'd11, 64'd12, 64'd13, 64'd14);
    push_key(64'd21, 64'd22, 64'd23, 64'd24);
    push_key(64'd11, 64'd12, 64'd13, 64'd14);
    push_key(64'd31, 64'd32, 64'd33, 64'd34);
    push_key(64'd11, 64'd12, 64'd13, 64'd14);
    drain_lookups();

    set_config(64, 2);
    push_key(64'd21, 64'd22, '1, '0);
    push_key(64'd21, 64'd23, 64'd23, 64'd24);
    drain_lookups();

    while (random_cnt < 1200) begin
      if ($urandom_range(0, 3) == 0) set_config($urandom_range(0, 127), $urandom_range(0, 7));
      else set_config(cap_choices[$urandom_range(0, 13)], $urandom_range(0, 7));
      n = $urandom_range(30, 150);
      if (n > 1200 - random_cnt) n = 1200 - random_cnt;
      repeat (n) begin
        pending_keys.insert(pending_keys.size(), next_key());
        random_cnt++;
      end
      drain_lookups();
    end

    repeat (80) @(posedge clk_i);
    if (predicted_outcomes.size() != 0) begin
      fail_cnt += predicted_outcomes.size();
      $display("%0d lookups never produced a result beat", predicted_outcomes.size());
    end
    $display("Ran %0d lookups over %0d register settings: %0d hits, %0d evictions.",
             lookup_cnt, phase_cnt, hit_cnt, evict_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("Failures: %0d", fail_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #(12 * 2000000);
    $display("Run did not finish in time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- lru_keyed_entry_cache.f -----
rtl/lkc_pkg.sv
rtl/lkc_key_ram.sv
rtl/lkc_seq.sv
rtl/lkc_scan.sv
rtl/lkc_lanes.sv
rtl/lru_keyed_entry_cache.sv
rtl/lkc_checker.sv
bench/testbench.sv
